// File: rtl/atte_pkg.sv
// Shared constants, types and helpers of the ANSI text terminal engine.
package atte_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_PARAMS = 16;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COLS_W  = $clog2(MAX_COLS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int PIDX_W  = $clog2(MAX_PARAMS);
    localparam int PCNT_W  = $clog2(MAX_PARAMS + 1);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int CODE_W  = 21;
    localparam int CELL_W  = CODE_W + 8;

    localparam logic [3:0]        DEF_FG     = 4'd7;
    localparam logic [3:0]        DEF_BG     = 4'd0;
    localparam logic [CODE_W-1:0] SPACE_CODE = CODE_W'(32);
    localparam logic [CELL_W-1:0] BLANK_CELL = {DEF_BG, DEF_FG, SPACE_CODE};

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } atte_wr_t;

    // physical address of visible row r, column c
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                     input logic [ROW_W-1:0] r,
                                                     input logic [COL_W-1:0] c);
        logic [ROW_W-1:0] pr;
        pr = ROW_W'(top + r);
        return {pr, c};
    endfunction

endpackage

// File: rtl/atte_screen_ram.sv
// Screen cell memory with a clearing pass after reset.
module atte_screen_ram
    import atte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  atte_wr_t          wr,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata,
    output logic              busy
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_cnt_reg] <= BLANK_CELL;
        else if (wr.en)
            mem[wr.addr] <= wr.data;
        rdata <= mem[raddr];
    end

    assign busy = busy_reg;

endmodule

// File: rtl/ansi_text_terminal_engine_top.sv
// Top level of the ANSI text terminal engine: parser, cursor and screen update.
//
// Host bytes and cell reads enter one transaction at a time on the s_ side and each
// gives one result on the m_ side. After reset the screen memory is cleared one cell
// a cycle over all 8192 cells, during which no transaction is accepted. A cell read
// steps through accept, memory read and result; a byte that writes no cell through
// accept, execute and result. A printed character adds a sweep of its cell, plus a
// row of screen_cols cells when it scrolls. CSI final letters add a CSI run step; SGR
// steps through its parameters one a cycle. Clears (J, K, ESC c) and LF scrolls
// sweep the screen memory's single write port one cell a cycle. A new transaction
// is taken while the previous result still waits in the output register.
module ansi_text_terminal_engine_top
    import atte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // data_byte[7:0], read_row[13:8], read_col[20:14]
    input  logic [0:0]  s_tuser,  // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // dirty_valid[0], dirty_first[6:1], dirty_last[12:7],
                                  // cell_code[33:13], cell_fg[37:34], cell_bg[41:38],
                                  // cursor_row_out[47:42], cursor_col_out[54:48]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE, S_RDWAIT, S_EXEC, S_CSIRUN, S_SGR, S_SWEEP, S_FINISH
    } state_t;

    typedef enum logic [1:0] { M_NORMAL, M_ESCAPE, M_CSI } pmode_t;

    state_t            state_reg, state_next;
    pmode_t            mode_reg, mode_next;
    logic [7:0]        byte_reg, byte_next;
    logic [1:0]        upend_reg, upend_next;
    logic [CODE_W-1:0] uacc_reg, uacc_next;
    logic [ROW_W-1:0]  row_reg, row_next, top_reg, top_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [3:0]        fg_reg, fg_next, bg_reg, bg_next, bright_reg, bright_next;
    logic [15:0]       vals_reg [MAX_PARAMS];
    logic [PCNT_W-1:0] cnt_reg, cnt_next, sgr_i_reg, sgr_i_next;
    logic              seen_reg, seen_next;
    logic [COLS_W-1:0] cols_reg, cols_next;
    logic [ROWS_W-1:0] rows_reg, rows_next;
    logic [ROW_W-1:0]  sw_r_reg, sw_r_next, sw_er_reg, sw_er_next;
    logic [COL_W-1:0]  sw_c_reg, sw_c_next, sw_ec_reg, sw_ec_next;
    logic [CODE_W-1:0] sw_code_reg, sw_code_next;
    logic              scroll_reg, scroll_next;
    logic              dv_reg, dv_next, inrng_reg, inrng_next;
    logic [ROW_W-1:0]  dlo_reg, dlo_next, dhi_reg, dhi_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [55:0]       m_tdata_reg, m_tdata_next;

    // parameter store write port
    logic              pw_en;
    logic [PIDX_W-1:0] pw_idx;
    logic [15:0]       pw_data;

    atte_wr_t          ram_wr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic              ram_busy;

    atte_screen_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (ram_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .busy  (ram_busy)
    );

    logic [7:0]       in_byte;
    logic [ROW_W-1:0] in_row;
    logic [COL_W-1:0] in_col;
    assign in_byte = s_tdata[7:0];
    assign in_row  = s_tdata[13:8];
    assign in_col  = s_tdata[20:14];

    assign s_tready  = (state_reg == S_IDLE) && !ram_busy;
    assign ram_raddr = cell_addr(top_reg, in_row, in_col);

    assign ram_wr.en   = (state_reg == S_SWEEP);
    assign ram_wr.addr = cell_addr(top_reg, sw_r_reg, sw_c_reg);
    assign ram_wr.data = {bg_reg, fg_reg, sw_code_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic [ROW_W-1:0]  rows_m1;
    logic [COL_W-1:0]  cols_m1;
    assign rows_m1 = ROW_W'(rows_reg - 1'b1);
    assign cols_m1 = COL_W'(cols_reg - 1'b1);

    // read address into the parameter store shared by digits and SGR; p0/p1 read entries 0 and 1
    logic [PIDX_W-1:0] prd_idx;
    logic [15:0]       prd;
    assign prd_idx = (state_reg == S_SGR) ? sgr_i_reg[PIDX_W-1:0] : cnt_reg[PIDX_W-1:0];
    assign prd     = vals_reg[prd_idx];

    logic [15:0] p0, p1, n0, n1;
    assign p0 = (cnt_reg > PCNT_W'(0)) ? vals_reg[0] : 16'd0;
    assign p1 = (cnt_reg > PCNT_W'(1)) ? vals_reg[1] : 16'd0;
    assign n0 = (p0 == 16'd0) ? 16'd1 : p0;
    assign n1 = (p1 == 16'd0) ? 16'd1 : p1;

    always_comb
    begin
        logic              do_put, handled, is_cont;
        logic [CODE_W-1:0] put_code, acc;
        logic [19:0]       prod;
        logic [15:0]       dv16, hr, hc;
        logic [16:0]       sum;
        logic [COLS_W-1:0] newc;
        logic [ROWS_W-1:0] newr;

        state_next    = state_reg;
        mode_next     = mode_reg;
        byte_next     = byte_reg;
        upend_next    = upend_reg;
        uacc_next     = uacc_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        top_next      = top_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        bright_next   = bright_reg;
        cnt_next      = cnt_reg;
        sgr_i_next    = sgr_i_reg;
        seen_next     = seen_reg;
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        sw_r_next     = sw_r_reg;
        sw_c_next     = sw_c_reg;
        sw_er_next    = sw_er_reg;
        sw_ec_next    = sw_ec_reg;
        sw_code_next  = sw_code_reg;
        scroll_next   = scroll_reg;
        dv_next       = dv_reg;
        dlo_next      = dlo_reg;
        dhi_next      = dhi_reg;
        inrng_next    = inrng_reg;
        cell_next     = cell_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        pw_en         = 1'b0;
        pw_idx        = cnt_reg[PIDX_W-1:0];
        pw_data       = 16'd0;
        do_put        = 1'b0;
        handled       = 1'b0;
        is_cont       = (byte_reg[7:6] == 2'b10);
        put_code      = {13'd0, byte_reg};
        acc           = CODE_W'({uacc_reg, byte_reg[5:0]});
        prod          = 20'd0;
        dv16          = 16'd0;
        hr            = 16'd0;
        hc            = 16'd0;
        sum           = 17'd0;
        newc          = cols_reg;
        newr          = rows_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    dv_next   = 1'b0;
                    dlo_next  = '0;
                    dhi_next  = '0;
                    cell_next = '0;
                    if (s_tuser[0])
                    begin
                        inrng_next = ({1'b0, in_row} < rows_reg) && ({1'b0, in_col} < cols_reg);
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        byte_next  = in_byte;
                        state_next = S_EXEC;
                    end
                end
            end

            S_RDWAIT:
            begin
                cell_next  = inrng_reg ? ram_rdata : '0;
                state_next = S_FINISH;
            end

            S_EXEC:
            begin
                state_next = S_FINISH;
                unique case (mode_reg)
                    M_ESCAPE:
                    begin
                        mode_next = M_NORMAL;
                        if (byte_reg == 8'h5B)
                        begin
                            mode_next = M_CSI;
                            cnt_next  = '0;
                            seen_next = 1'b0;
                        end
                        else if (byte_reg == 8'h63)
                        begin
                            fg_next      = DEF_FG;
                            bg_next      = DEF_BG;
                            sw_r_next    = '0;
                            sw_c_next    = '0;
                            sw_er_next   = rows_m1;
                            sw_ec_next   = cols_m1;
                            sw_code_next = SPACE_CODE;
                            row_next     = '0;
                            col_next     = '0;
                            dv_next      = 1'b1;
                            dlo_next     = '0;
                            dhi_next     = rows_m1;
                            state_next   = S_SWEEP;
                        end
                    end

                    M_CSI:
                    begin
                        if (byte_reg >= 8'h30 && byte_reg <= 8'h39)
                        begin
                            if (cnt_reg < PCNT_W'(MAX_PARAMS))
                            begin
                                dv16      = seen_reg ? prd : 16'd0;
                                prod      = {dv16, 3'b000} + {3'b000, dv16, 1'b0}
                                          + {16'd0, byte_reg[3:0]};
                                pw_en     = 1'b1;
                                pw_data   = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];
                                seen_next = 1'b1;
                            end
                        end
                        else if (byte_reg == 8'h3B ||
                                 (byte_reg >= 8'h41 && byte_reg <= 8'h5A) ||
                                 (byte_reg >= 8'h61 && byte_reg <= 8'h7A))
                        begin
                            // close the open parameter
                            if (cnt_reg < PCNT_W'(MAX_PARAMS))
                            begin
                                pw_en    = !seen_reg;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            seen_next = 1'b0;
                            if (byte_reg != 8'h3B)
                            begin
                                mode_next  = M_NORMAL;
                                state_next = S_CSIRUN;
                            end
                        end
                    end

                    default:
                    begin
                        if (upend_reg != 2'd0)
                        begin
                            if (is_cont)
                            begin
                                handled    = 1'b1;
                                uacc_next  = acc;
                                upend_next = upend_reg - 1'b1;
                                if (upend_reg == 2'd1)
                                begin
                                    do_put   = 1'b1;
                                    put_code = acc;
                                end
                            end
                            else
                                upend_next = 2'd0;
                        end
                        if (!handled)
                        begin
                            priority case (byte_reg)
                                8'h1B: mode_next = M_ESCAPE;
                                8'h0A:
                                begin
                                    col_next = '0;
                                    dv_next  = 1'b1;
                                    if ({1'b0, row_reg} + 1'b1 >= rows_reg)
                                    begin
                                        top_next     = top_reg + 1'b1;
                                        row_next     = rows_m1;
                                        sw_r_next    = rows_m1;
                                        sw_c_next    = '0;
                                        sw_er_next   = rows_m1;
                                        sw_ec_next   = cols_m1;
                                        sw_code_next = SPACE_CODE;
                                        dlo_next     = '0;
                                        dhi_next     = rows_m1;
                                        state_next   = S_SWEEP;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + 1'b1;
                                        dlo_next = row_reg + 1'b1;
                                        dhi_next = row_reg + 1'b1;
                                    end
                                end
                                8'h0D:
                                begin
                                    col_next = '0;
                                    dv_next  = 1'b1;
                                    dlo_next = row_reg;
                                    dhi_next = row_reg;
                                end
                                8'h08:
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next     = col_reg - 1'b1;
                                        sw_r_next    = row_reg;
                                        sw_er_next   = row_reg;
                                        sw_c_next    = col_reg - 1'b1;
                                        sw_ec_next   = col_reg - 1'b1;
                                        sw_code_next = SPACE_CODE;
                                        dv_next      = 1'b1;
                                        dlo_next     = row_reg;
                                        dhi_next     = row_reg;
                                        state_next   = S_SWEEP;
                                    end
                                end
                                8'h09:
                                begin
                                    // next tab stop may lie one past the widest screen
                                    newc = {5'(col_reg[COL_W-1:3]) + 5'd1, 3'b000};
                                    if (newc >= cols_reg)
                                        col_next = cols_m1;
                                    else
                                        col_next = newc[COL_W-1:0];
                                end
                                8'h07: ;
                                default:
                                begin
                                    if (!byte_reg[7])
                                        do_put = 1'b1;
                                    else if (byte_reg[7:5] == 3'b110)
                                    begin
                                        uacc_next  = CODE_W'(byte_reg[4:0]);
                                        upend_next = 2'd1;
                                    end
                                    else if (byte_reg[7:4] == 4'b1110)
                                    begin
                                        uacc_next  = CODE_W'(byte_reg[3:0]);
                                        upend_next = 2'd2;
                                    end
                                    else if (byte_reg[7:3] == 5'b11110)
                                    begin
                                        uacc_next  = CODE_W'(byte_reg[2:0]);
                                        upend_next = 2'd3;
                                    end
                                end
                            endcase
                        end
                        if (do_put)
                        begin
                            // write the cell at the old cursor and advance the cursor; a scroll follows the write
                            sw_r_next    = row_reg;
                            sw_er_next   = row_reg;
                            sw_c_next    = col_reg;
                            sw_ec_next   = col_reg;
                            sw_code_next = put_code;
                            dv_next      = 1'b1;
                            dlo_next     = row_reg;
                            dhi_next     = row_reg;
                            state_next   = S_SWEEP;
                            if ({1'b0, col_reg} + 1'b1 >= cols_reg)
                            begin
                                col_next = '0;
                                if ({1'b0, row_reg} + 1'b1 >= rows_reg)
                                begin
                                    row_next    = rows_m1;
                                    scroll_next = 1'b1;
                                    dlo_next    = '0;
                                    dhi_next    = rows_m1;
                                end
                                else
                                    row_next = row_reg + 1'b1;
                            end
                            else
                                col_next = col_reg + 1'b1;
                        end
                    end
                endcase
            end

            S_CSIRUN:
            begin
                state_next   = S_FINISH;
                sw_code_next = SPACE_CODE;
                unique case (byte_reg)
                    8'h6D:
                    begin
                        bright_next = 4'd0;
                        sgr_i_next  = '0;
                        if (cnt_reg != '0)
                            state_next = S_SGR;
                    end
                    8'h48:
                    begin
                        hr = n0 - 1'b1;
                        hc = n1 - 1'b1;
                        row_next = (hr > {10'd0, rows_m1}) ? rows_m1 : hr[ROW_W-1:0];
                        col_next = (hc > {9'd0, cols_m1}) ? cols_m1 : hc[COL_W-1:0];
                    end
                    8'h41:
                        row_next = (n0 >= {10'd0, row_reg}) ? '0 : ROW_W'(row_reg - n0);
                    8'h42:
                    begin
                        sum      = {11'd0, row_reg} + {1'b0, n0};
                        row_next = (sum > {11'd0, rows_m1}) ? rows_m1 : sum[ROW_W-1:0];
                    end
                    8'h43:
                    begin
                        sum      = {10'd0, col_reg} + {1'b0, n0};
                        col_next = (sum > {10'd0, cols_m1}) ? cols_m1 : sum[COL_W-1:0];
                    end
                    8'h44:
                        col_next = (n0 >= {9'd0, col_reg}) ? '0 : COL_W'(col_reg - n0);
                    8'h4A:
                    begin
                        state_next = S_SWEEP;
                        dv_next    = 1'b1;
                        if (p0 == 16'd1)
                        begin
                            sw_r_next  = '0;
                            sw_c_next  = '0;
                            sw_er_next = row_reg;
                            sw_ec_next = col_reg;
                            dlo_next   = '0;
                            dhi_next   = row_reg;
                        end
                        else if (p0 == 16'd2)
                        begin
                            sw_r_next  = '0;
                            sw_c_next  = '0;
                            sw_er_next = rows_m1;
                            sw_ec_next = cols_m1;
                            row_next   = '0;
                            col_next   = '0;
                            dlo_next   = '0;
                            dhi_next   = rows_m1;
                        end
                        else
                        begin
                            sw_r_next  = row_reg;
                            sw_c_next  = col_reg;
                            sw_er_next = rows_m1;
                            sw_ec_next = cols_m1;
                            dlo_next   = row_reg;
                            dhi_next   = rows_m1;
                        end
                    end
                    8'h4B:
                    begin
                        state_next = S_SWEEP;
                        dv_next    = 1'b1;
                        dlo_next   = row_reg;
                        dhi_next   = row_reg;
                        sw_r_next  = row_reg;
                        sw_er_next = row_reg;
                        sw_c_next  = (p0 == 16'd1 || p0 == 16'd2) ? '0 : col_reg;
                        sw_ec_next = (p0 == 16'd1) ? col_reg : cols_m1;
                    end
                    default: ;
                endcase
            end

            S_SGR:
            begin
                if (prd == 16'd0)
                begin
                    bright_next = 4'd0;
                    fg_next     = DEF_FG;
                    bg_next     = DEF_BG;
                end
                else if (prd == 16'd1)
                begin
                    bright_next = 4'd8;
                    fg_next     = 4'd15;
                end
                else if (prd >= 16'd30 && prd <= 16'd37)
                    fg_next = {bright_reg[3], 3'(prd - 16'd30)};
                else if (prd >= 16'd40 && prd <= 16'd47)
                    bg_next = {bright_reg[3], 3'(prd - 16'd40)};
                else if (prd >= 16'd90 && prd <= 16'd97)
                    fg_next = {1'b1, 3'(prd - 16'd90)};
                else if (prd >= 16'd100 && prd <= 16'd107)
                    bg_next = {1'b1, 3'(prd - 16'd100)};
                sgr_i_next = sgr_i_reg + 1'b1;
                if (sgr_i_reg + 1'b1 == cnt_reg)
                    state_next = S_FINISH;
            end

            S_SWEEP:
            begin
                if (sw_r_reg == sw_er_reg && sw_c_reg == sw_ec_reg)
                begin
                    if (scroll_reg)
                    begin
                        // wrapped below the last row: roll the top and blank the new last row
                        scroll_next  = 1'b0;
                        top_next     = top_reg + 1'b1;
                        sw_r_next    = rows_m1;
                        sw_er_next   = rows_m1;
                        sw_c_next    = '0;
                        sw_ec_next   = cols_m1;
                        sw_code_next = SPACE_CODE;
                    end
                    else
                        state_next = S_FINISH;
                end
                else if (sw_c_reg == cols_m1)
                begin
                    sw_c_next = '0;
                    sw_r_next = sw_r_reg + 1'b1;
                end
                else
                    sw_c_next = sw_c_reg + 1'b1;
            end

            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, col_reg, row_reg, cell_reg, dhi_reg, dlo_reg, dv_reg};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // register writes must arrive only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            if (cfg_index == CFG_COLS)
            begin
                newc = (cfg_data == 8'd0) ? COLS_W'(1)
                     : (cfg_data > 8'(MAX_COLS)) ? COLS_W'(MAX_COLS) : COLS_W'(cfg_data);
                cols_next = newc;
                if ({1'b0, col_reg} >= newc)
                    col_next = COL_W'(newc - 1'b1);
            end
            else if (cfg_index == CFG_ROWS)
            begin
                newr = (cfg_data[6:0] == 7'd0) ? ROWS_W'(1)
                     : (cfg_data[6:0] > 7'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                     : ROWS_W'(cfg_data[6:0]);
                rows_next = newr;
                if ({1'b0, row_reg} >= newr)
                    row_next = ROW_W'(newr - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
            vals_reg[pw_idx] <= pw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= M_NORMAL;
            upend_reg    <= 2'd0;
            uacc_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            top_reg      <= '0;
            fg_reg       <= DEF_FG;
            bg_reg       <= DEF_BG;
            bright_reg   <= 4'd0;
            cnt_reg      <= '0;
            sgr_i_reg    <= '0;
            seen_reg     <= 1'b0;
            cols_reg     <= COLS_W'(80);
            rows_reg     <= ROWS_W'(24);
            scroll_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            upend_reg    <= upend_next;
            uacc_reg     <= uacc_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            top_reg      <= top_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            bright_reg   <= bright_next;
            cnt_reg      <= cnt_next;
            sgr_i_reg    <= sgr_i_next;
            seen_reg     <= seen_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            scroll_reg   <= scroll_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        sw_r_reg    <= sw_r_next;
        sw_c_reg    <= sw_c_next;
        sw_er_reg   <= sw_er_next;
        sw_ec_reg   <= sw_ec_next;
        sw_code_reg <= sw_code_next;
        dv_reg      <= dv_next;
        dlo_reg     <= dlo_next;
        dhi_reg     <= dhi_next;
        inrng_reg   <= inrng_next;
        cell_reg    <= cell_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
